// ===== sv/round_robin_sample_player_unit_assert.svh =====
// assertion macros for the round-robin sample player
`ifndef ROUND_ROBIN_SAMPLE_PLAYER_UNIT_ASSERT_SVH
`define ROUND_ROBIN_SAMPLE_PLAYER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define RRSP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rrsp check failed");

`define RRSP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rrsp check failed");

`else

`define RRSP_ASSERT_IMP(lbl, ante, cons)
`define RRSP_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== sv/rrsp_pkg.sv =====
// shared types and constants of the round-robin sample player
`timescale 1ns / 1ps
`default_nettype none

package rrsp_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned CH_FLD_W = 2;
  localparam int unsigned SID_FLD_W = 3;
  localparam int unsigned ADDR_W   = 15;
  localparam int unsigned LEN_W    = 15;
  localparam int unsigned SMP_W    = 8;
  localparam int unsigned DAC_W    = 4;

  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK        = 2'd0,
    CMD_PLAY        = 2'd1,
    CMD_LOAD_SAMPLE = 2'd2,
    CMD_LOAD_SOUND  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e                 cmd;
    logic [CH_FLD_W-1:0]  channel;
    logic [SID_FLD_W-1:0] sound_id;
    logic [ADDR_W-1:0]    address;
    logic [LEN_W-1:0]     length;
    logic [SMP_W-1:0]     sample_byte;
  } in_item_t;

endpackage

`default_nettype wire

// ===== sv/round_robin_sample_player_unit.sv =====
// round-robin sample player: three-stage pipeline around the sample store and sound table
// path: an accepted word moves through the stage 1 and stage 2 registers into the stage 3 output register
// throughput: one word per cycle while the output is not stalled; the sound table read (stage 1) and the sample
// store read (stage 2) each take one memory port once per word
// reset: pipeline, channel pointers and counts, slot counter, running flag and
// sound table valid bits clear at once; sample store contents are undefined until written
`timescale 1ns / 1ps
`default_nettype none
`include "round_robin_sample_player_unit_assert.svh"

module round_robin_sample_player_unit
  import rrsp_pkg::*;
#(
  parameter int CHANNELS    = 4,
  parameter int SOUNDS      = 8,
  parameter int STORE_DEPTH = 32768
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // channel, sound_id, address, length, sample_byte, zero fill
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // cmd
  input  wire logic [CMD_W-1:0]       s_axis_tuser_i,
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  // dac_value, served_channel, running, zero fill
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o,
  // dac_valid
  output logic                        m_axis_tuser_o
);

  localparam int unsigned CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SID_W  = (SOUNDS > 1) ? $clog2(SOUNDS) : 1;
  localparam int unsigned IDX_W  = $clog2(STORE_DEPTH);
  localparam int unsigned MUL_W  = ADDR_W + 2;
  localparam int unsigned PROD_W = ADDR_W + MUL_W;
  localparam int unsigned MOD_SH = ADDR_W + IDX_W;
  localparam int unsigned RED_W  = ADDR_W + IDX_W + 1;
  localparam longint unsigned MOD_M =
    ((64'd1 << MOD_SH) + longint'(STORE_DEPTH) - 64'd1) / longint'(STORE_DEPTH);
  localparam logic [MUL_W-1:0] MOD_M_C   = MUL_W'(MOD_M);
  localparam logic [RED_W-1:0] DEPTH_C   = RED_W'(STORE_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(STORE_DEPTH - 1);
  localparam logic [CH_W-1:0]  SLOT_LAST = CH_W'(CHANNELS - 1);

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  len;
    logic [IDX_W-1:0]  sidx;
  } snd_ent_t;

  // pipeline handshake
  logic s1_v_q, s2_v_q, s3_v_q;
  logic en1, en2, en3;

  assign en3 = !s3_v_q || m_axis_tready_i;
  assign en2 = !s2_v_q || en3;
  assign en1 = !s1_v_q || en2;
  assign s_axis_tready_o = en1;

  in_item_t in_item;
  assign in_item = '{
    cmd:         cmd_e'(s_axis_tuser_i),
    channel:     s_axis_tdata_i[1:0],
    sound_id:    s_axis_tdata_i[4:2],
    address:     s_axis_tdata_i[19:5],
    length:      s_axis_tdata_i[34:20],
    sample_byte: s_axis_tdata_i[42:35]
  };

  // stage 1 registers
  in_item_t          s1_q;
  logic [PROD_W-1:0] s1_prod_q;

  // stage 2 registers
  cmd_e                s2_cmd_q;
  logic [CH_FLD_W-1:0] s2_ch_q;
  logic                s2_sid_ok_q;
  snd_ent_t            s2_tbl_q;
  logic                s2_tvld_q;

  // stage 3 registers
  logic             s3_dval_q;
  logic [1:0]       s3_served_q;
  logic             s3_run_q;
  logic [SMP_W-1:0] smp_q;

  // channel state
  logic [ADDR_W-1:0] ptr_q [CHANNELS];
  logic [ADDR_W-1:0] ptr_d [CHANNELS];
  logic [IDX_W-1:0]  idx_q [CHANNELS];
  logic [IDX_W-1:0]  idx_d [CHANNELS];
  logic [LEN_W-1:0]  rem_q [CHANNELS];
  logic [LEN_W-1:0]  rem_d [CHANNELS];
  logic [CH_W-1:0]   slot_q, slot_d;
  logic              playing_q, playing_d;
  logic [CHANNELS-1:0] rem_nz;

  // memories
  snd_ent_t         tbl_mem [SOUNDS];
  logic             tbl_vld_q [SOUNDS];
  logic [SMP_W-1:0] store_mem [STORE_DEPTH];

  // stage 1: address reduction and memory writes
  logic [ADDR_W-1:0] s1_quot;
  logic [RED_W-1:0]  s1_red_raw;
  logic [RED_W-1:0]  s1_red;
  logic [IDX_W-1:0]  s1_idx;
  logic [SID_W-1:0]  s1_sidx;
  logic              s1_sid_ok;
  logic              tbl_we;
  logic              st_we;
  snd_ent_t          tbl_wdata;

  assign s1_quot    = ADDR_W'(s1_prod_q >> MOD_SH);
  assign s1_red_raw = RED_W'(s1_q.address) - RED_W'(s1_quot) * DEPTH_C;
  assign s1_red     = (s1_red_raw >= DEPTH_C) ? s1_red_raw - DEPTH_C : s1_red_raw;
  assign s1_idx     = IDX_W'(s1_red);
  assign s1_sidx    = SID_W'(s1_q.sound_id);
  assign s1_sid_ok  = 32'(s1_q.sound_id) < SOUNDS;
  assign tbl_we     = en2 && s1_v_q && (s1_q.cmd == CMD_LOAD_SOUND) && s1_sid_ok;
  assign st_we      = en2 && s1_v_q && (s1_q.cmd == CMD_LOAD_SAMPLE);
  assign tbl_wdata  = '{start: s1_q.address, len: s1_q.length, sidx: s1_idx};

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[s1_sidx] <= tbl_wdata;
    end
    if (en2) begin
      s2_tbl_q <= tbl_mem[s1_sidx];
    end
  end

  // stage 2: channel update and sample read
  snd_ent_t         ent;
  logic [CH_W-1:0]  play_ch;
  logic             tick_dval;
  logic [1:0]       tick_served;
  logic [IDX_W-1:0] rd_idx;
  logic             any_rem;

  assign ent     = s2_tvld_q ? s2_tbl_q : '0;
  assign play_ch = CH_W'(s2_ch_q);
  assign rd_idx  = idx_q[slot_q];

  always_comb begin
    ptr_d       = ptr_q;
    idx_d       = idx_q;
    rem_d       = rem_q;
    slot_d      = slot_q;
    playing_d   = playing_q;
    tick_dval   = 1'b0;
    tick_served = '0;
    any_rem     = 1'b0;
    if (s2_v_q) begin
      unique case (s2_cmd_q)
        CMD_TICK: begin
          if (playing_q) begin
            tick_served = 2'(slot_q);
            slot_d = (slot_q == SLOT_LAST) ? '0 : CH_W'(slot_q + 1'b1);
            if (rem_q[slot_q] != '0) begin
              tick_dval = 1'b1;
              ptr_d[slot_q] = ADDR_W'(ptr_q[slot_q] + 1'b1);
              rem_d[slot_q] = LEN_W'(rem_q[slot_q] - 1'b1);
              if (ptr_q[slot_q] == '1 || idx_q[slot_q] == IDX_LAST) begin
                idx_d[slot_q] = '0;
              end else begin
                idx_d[slot_q] = IDX_W'(idx_q[slot_q] + 1'b1);
              end
            end
            for (int i = 0; i < CHANNELS; i++) begin
              any_rem = any_rem | (rem_d[i] != '0);
            end
            playing_d = any_rem;
          end
        end
        CMD_PLAY: begin
          if (s2_sid_ok_q && (32'(s2_ch_q) < CHANNELS)) begin
            ptr_d[play_ch] = ent.start;
            idx_d[play_ch] = ent.sidx;
            rem_d[play_ch] = ent.len;
            playing_d = 1'b1;
          end
        end
        CMD_LOAD_SAMPLE, CMD_LOAD_SOUND: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      store_mem[s1_idx] <= s1_q.sample_byte;
    end
    if (en3) begin
      smp_q <= store_mem[rd_idx];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      s3_v_q    <= 1'b0;
      slot_q    <= '0;
      playing_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        ptr_q[i] <= '0;
        idx_q[i] <= '0;
        rem_q[i] <= '0;
      end
      for (int j = 0; j < SOUNDS; j++) begin
        tbl_vld_q[j] <= 1'b0;
      end
    end else begin
      if (en1) begin
        s1_v_q <= s_axis_tvalid_i;
      end
      if (en2) begin
        s2_v_q <= s1_v_q;
      end
      if (en3) begin
        s3_v_q <= s2_v_q;
      end
      if (tbl_we) begin
        tbl_vld_q[s1_sidx] <= 1'b1;
      end
      if (en3 && s2_v_q) begin
        ptr_q     <= ptr_d;
        idx_q     <= idx_d;
        rem_q     <= rem_d;
        slot_q    <= slot_d;
        playing_q <= playing_d;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_q      <= in_item;
      s1_prod_q <= PROD_W'(in_item.address) * PROD_W'(MOD_M_C);
    end
    if (en2) begin
      s2_cmd_q    <= s1_q.cmd;
      s2_ch_q     <= s1_q.channel;
      s2_sid_ok_q <= s1_sid_ok;
      s2_tvld_q   <= tbl_vld_q[s1_sidx];
    end
    if (en3) begin
      s3_dval_q   <= tick_dval;
      s3_served_q <= tick_served;
      s3_run_q    <= playing_d;
    end
  end

  // output word
  logic [DAC_W-1:0] dac_value;

  assign dac_value       = s3_dval_q ? smp_q[SMP_W-1:SMP_W-DAC_W] : '0;
  assign m_axis_tvalid_o = s3_v_q;
  assign m_axis_tuser_o  = s3_dval_q;
  assign m_axis_tdata_o  = {1'b0, s3_run_q, s3_served_q, dac_value};

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      rem_nz[i] = (rem_q[i] != '0);
    end
  end

  `RRSP_ASSERT_IMP(a_stopped_no_rem, !playing_q, rem_nz == '0)
  `RRSP_ASSERT_IMP(a_slot_range, 1'b1, 32'(slot_q) < CHANNELS)
  `RRSP_ASSERT_IMP(a_busy_holds_s1, !s_axis_tready_o, s1_v_q)
  `RRSP_ASSERT_NXT(a_s2_kept, s2_v_q && !en3, s2_v_q)

endmodule

`default_nettype wire

// ===== bench/round_robin_sample_player_unit_tb.sv =====
// self-checking testbench for the round-robin sample player: directed and random commands
`timescale 1ns / 1ps

module round_robin_sample_player_unit_tb
  import rrsp_pkg::*;
();

  localparam int STORE_SLOTS  = 32768;
  localparam int NUM_CHANNELS = 4;
  localparam int NUM_SOUNDS   = 8;
  localparam int RANDOM_ITEMS = 380;
  localparam int DRAIN_LIMIT  = 200000;

  typedef struct packed {
    bit                dac_valid;
    logic [DAC_W-1:0]  dac_value;
    logic [1:0]        served_channel;
    bit                running;
  } dac_word_t;

  class dac_predictor;
    bit [SMP_W-1:0]  store_bytes [STORE_SLOTS];
    bit              store_written [STORE_SLOTS];
    bit [ADDR_W-1:0] sound_start [NUM_SOUNDS];
    bit [LEN_W-1:0]  sound_len [NUM_SOUNDS];
    bit [ADDR_W-1:0] chan_ptr [NUM_CHANNELS];
    bit [LEN_W-1:0]  chan_left [NUM_CHANNELS];
    bit [1:0]        next_slot;
    bit              playing;
    dac_word_t       pending_words [$];
    int unsigned     mismatches;
    int unsigned     commands_seen;
    int unsigned     words_checked;
    int unsigned     samples_played;

    // true when the next tick would fetch a store byte that was never loaded
    function bit tick_reads_blank(output bit [ADDR_W-1:0] addr);
      addr = chan_ptr[next_slot];
      return playing && chan_left[next_slot] != 0 && !store_written[addr];
    endfunction

    function void accept_command(in_item_t it);
      dac_word_t w;
      bit any_left;
      w = '0;
      commands_seen++;
      case (it.cmd)
        CMD_TICK: begin
          if (playing) begin
            w.served_channel = next_slot;
            if (chan_left[next_slot] != 0) begin
              w.dac_valid = 1'b1;
              w.dac_value = store_bytes[chan_ptr[next_slot]][SMP_W-1 -: DAC_W];
              chan_ptr[next_slot]++;
              chan_left[next_slot]--;
            end
            next_slot++;
            any_left = 1'b0;
            foreach (chan_left[c]) if (chan_left[c] != 0) any_left = 1'b1;
            if (!any_left) playing = 1'b0;
          end
        end
        CMD_PLAY: begin
          chan_ptr[it.channel]  = sound_start[it.sound_id];
          chan_left[it.channel] = sound_len[it.sound_id];
          playing = 1'b1;
        end
        CMD_LOAD_SAMPLE: begin
          store_bytes[it.address]   = it.sample_byte;
          store_written[it.address] = 1'b1;
        end
        CMD_LOAD_SOUND: begin
          sound_start[it.sound_id] = it.address;
          sound_len[it.sound_id]   = it.length;
        end
      endcase
      w.running = playing;
      pending_words.push_back(w);
    endfunction

    function void check_dac_word(dac_word_t got);
      dac_word_t want;
      if (pending_words.size() == 0) begin
        $error("DAC word with nothing expected: valid %0d value %0h channel %0d running %0d",
               got.dac_valid, got.dac_value, got.served_channel, got.running);
        mismatches++;
        return;
      end
      want = pending_words.pop_front();
      words_checked++;
      if (got.dac_valid) samples_played++;
      if (got.dac_valid !== want.dac_valid) begin
        $error("dac_valid: expected %0d, got %0d", want.dac_valid, got.dac_valid);
        mismatches++;
      end
      if (got.dac_value !== want.dac_value) begin
        $error("dac_value: expected %0h, got %0h", want.dac_value, got.dac_value);
        mismatches++;
      end
      if (got.served_channel !== want.served_channel) begin
        $error("served_channel: expected %0d, got %0d", want.served_channel,
               got.served_channel);
        mismatches++;
      end
      if (got.running !== want.running) begin
        $error("running: expected %0d, got %0d", want.running, got.running);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic [CMD_W-1:0]      s_tuser = '0;
  logic                  m_tready = 1'b0;
  logic                  s_axis_tready_o;
  logic                  m_axis_tvalid_o;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                  m_axis_tuser_o;

  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  dac_predictor predictor = new();

  round_robin_sample_player_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #2 clk_i = ~clk_i;

  // output side: check accepted words, then pick the next ready level
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_tready) begin
        predictor.check_dac_word('{dac_valid: m_axis_tuser_o,
                                   dac_value: m_axis_tdata_o[3:0],
                                   served_channel: m_axis_tdata_o[5:4],
                                   running: m_axis_tdata_o[6]});
      end
      m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  function automatic in_item_t make_cmd(cmd_e c, int ch, int sid, int addr, int len, int smp);
    in_item_t it;
    it.cmd         = c;
    it.channel     = ch[1:0];
    it.sound_id    = sid[2:0];
    it.address     = addr[ADDR_W-1:0];
    it.length      = len[LEN_W-1:0];
    it.sample_byte = smp[SMP_W-1:0];
    return it;
  endfunction

  task automatic send_word(in_item_t it);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < src_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, it.sample_byte, it.length, it.address, it.sound_id, it.channel};
    s_tuser  <= it.cmd;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predictor.accept_command(it);
  endtask

  // ticks that would fetch a never-loaded byte get that byte loaded first
  task automatic issue_command(in_item_t it);
    bit [ADDR_W-1:0] blank_addr;
    if (it.cmd == CMD_TICK && predictor.tick_reads_blank(blank_addr)) begin
      send_word(make_cmd(CMD_LOAD_SAMPLE, $urandom, $urandom, blank_addr, $urandom, $urandom));
    end
    send_word(it);
  endtask

  function automatic in_item_t random_command();
    in_item_t it;
    int unsigned roll;
    int unsigned pick;
    it.channel     = CH_FLD_W'($urandom);
    it.sound_id    = SID_FLD_W'($urandom);
    it.address     = ADDR_W'($urandom);
    it.length      = LEN_W'($urandom);
    it.sample_byte = SMP_W'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      it.cmd = CMD_TICK;
    end else if (roll < 65) begin
      it.cmd = CMD_PLAY;
    end else if (roll < 82) begin
      it.cmd = CMD_LOAD_SAMPLE;
      // mostly near the start of some sound so that its bytes are real data
      if ($urandom_range(0, 3) != 0)
        it.address = ADDR_W'(predictor.sound_start[$urandom_range(0, NUM_SOUNDS - 1)]
                             + $urandom_range(0, 15));
    end else begin
      it.cmd = CMD_LOAD_SOUND;
      pick = $urandom_range(0, 19);
      if (pick == 0) it.length = '0;
      else if (pick < 18) it.length = LEN_W'($urandom_range(1, 12));
      if ($urandom_range(0, 9) == 0) it.address = ADDR_W'(STORE_SLOTS - $urandom_range(1, 4));
    end
    return it;
  endfunction

  initial begin
    int unsigned src_tbl [4]  = '{0, 88, 0, 29};
    int unsigned sink_tbl [4] = '{0, 0, 88, 29};
    int unsigned waited;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: stopped tick, table and store extremes, zero length, pointer wrap
    issue_command(make_cmd(CMD_TICK, 3, 7, 'h7fff, 'h7fff, 'hff));
    issue_command(make_cmd(CMD_LOAD_SAMPLE, 0, 0, 'h7fff, 0, 'hf0));
    issue_command(make_cmd(CMD_LOAD_SAMPLE, 3, 7, 0, 'h7fff, 'h5a));
    issue_command(make_cmd(CMD_LOAD_SOUND, 0, 0, 'h7fff, 2, 0));
    issue_command(make_cmd(CMD_LOAD_SOUND, 3, 7, 0, 0, 'hff));
    issue_command(make_cmd(CMD_LOAD_SOUND, 1, 5, 0, 'h7fff, 0));
    issue_command(make_cmd(CMD_PLAY, 0, 7, 0, 0, 0));
    issue_command(make_cmd(CMD_TICK, 0, 0, 0, 0, 0));
    issue_command(make_cmd(CMD_TICK, 0, 0, 0, 0, 0));
    issue_command(make_cmd(CMD_PLAY, 3, 0, 'h7fff, 'h7fff, 'hff));
    repeat (7) issue_command(make_cmd(CMD_TICK, 0, 0, 0, 0, 0));
    issue_command(make_cmd(CMD_PLAY, 1, 5, 0, 0, 0));
    repeat (3) issue_command(make_cmd(CMD_TICK, 2, 3, 'h1234, 'h4321, 'h0f));
    issue_command(make_cmd(CMD_PLAY, 1, 7, 0, 0, 0));
    issue_command(make_cmd(CMD_TICK, 0, 0, 0, 0, 0));

    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct   = src_tbl[ph];
      sink_stall_pct = sink_tbl[ph];
      repeat (RANDOM_ITEMS / 4) issue_command(random_command());
    end

    s_tvalid <= 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    waited = 0;
    while (predictor.pending_words.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    if (predictor.pending_words.size() != 0) begin
      $error("%0d expected DAC words never arrived", predictor.pending_words.size());
      predictor.mismatches++;
    end

    $display("covered %0d commands across four handshake pressure phases",
             predictor.commands_seen);
    $display("checked %0d output words, %0d of them carrying DAC samples",
             predictor.words_checked, predictor.samples_played);
    if (predictor.mismatches == 0) begin
      $display("round_robin_sample_player_unit_tb: done, clean");
    end else begin
      $display("round_robin_sample_player_unit_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("round_robin_sample_player_unit_tb: done, errors");
    $finish;
  end

endmodule
